>>> rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants, codes and controller/datapath interface types for the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACT_W    = 3;
    localparam int POS_W    = 9;
    localparam int VAL_W    = 32;
    localparam int FPOS_W   = 8;
    localparam int LEN_W    = 9;

    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE_POS = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE_VAL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_POS   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_NOTFOUND,
        ST_FULL
    } t_status;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT,
        WR_PUT
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_VAL,
        RES_ENTRY
    } t_res_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_LOOP,
        S_INS_WR,
        S_SCAN,
        S_CHECK,
        S_DEL_LOOP,
        S_DEL_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load_req;
        t_idx_op  idx_op;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     res_load;
        t_status  res_status;
        t_res_src res_src;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             pos_gt_count;
        logic             pos_ge_count;
        logic             count_full;
        logic             idx_gt_pos;
        logic             idx_lt_count;
        logic             idx_p1_lt_count;
        logic             val_match;
        logic             out_free;
    } t_dp_status;

endpackage

>>> rtl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl
// Request sequencer: decodes one request and steps the datapath through
// scan, shift and result phases.
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_fire,
    input  ole_pkg::t_dp_status i_status,
    output ole_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import ole_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_positional;
    logic   w_removes;
    logic   w_hit;

    assign w_positional = i_status.act inside {ACT_REMOVE_POS, ACT_READ_POS};
    assign w_removes    = i_status.act inside {ACT_REMOVE_POS, ACT_REMOVE_VAL};
    assign w_hit        = w_positional || i_status.val_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.act)
                    ACT_INSERT: begin
                        if (i_status.pos_gt_count || i_status.count_full) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_INS_LOOP;
                        end
                    end
                    ACT_REMOVE_POS, ACT_READ_POS: begin
                        n_state = i_status.pos_ge_count ? S_DONE : S_SCAN;
                    end
                    ACT_REMOVE_VAL, ACT_SEARCH: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_INS_LOOP: begin
                n_state = i_status.idx_gt_pos ? S_INS_WR : S_DONE;
            end
            S_INS_WR: begin
                n_state = S_INS_LOOP;
            end
            S_SCAN: begin
                n_state = i_status.idx_lt_count ? S_CHECK : S_DONE;
            end
            S_CHECK: begin
                if (w_hit) begin
                    n_state = w_removes ? S_DEL_LOOP : S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DEL_LOOP: begin
                n_state = i_status.idx_p1_lt_count ? S_DEL_WR : S_DONE;
            end
            S_DEL_WR: begin
                n_state = S_DEL_LOOP;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.wr_sel     = WR_SHIFT;
        o_cmd.res_status = ST_OK;
        o_cmd.res_src    = RES_ZERO;
        o_busy           = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy         = 1'b0;
                o_cmd.load_req = i_in_fire;
            end
            S_DECODE: begin
                case (i_status.act)
                    ACT_INSERT: begin
                        if (i_status.pos_gt_count) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end else if (i_status.count_full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_COUNT;
                        end
                    end
                    ACT_REMOVE_POS, ACT_READ_POS: begin
                        if (i_status.pos_ge_count) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                        end
                    end
                    ACT_REMOVE_VAL, ACT_SEARCH: begin
                        o_cmd.idx_op = IDX_ZERO;
                    end
                    default: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_RANGE;
                    end
                endcase
            end
            S_INS_LOOP: begin
                if (i_status.idx_gt_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                end else begin
                    // idx has reached the target position: drop the new value in
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_sel   = WR_PUT;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = RES_VAL;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_DEC;
            end
            S_SCAN: begin
                if (i_status.idx_lt_count) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOTFOUND;
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_src  = RES_ENTRY;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_DEL_LOOP: begin
                if (i_status.idx_p1_lt_count) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_IDX_P1;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = IDX_INC;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/ole_dp.sv
// ----------------------------------------------------------------------------
// ole_dp
// Entry memory, length counter, walk index, request and result registers,
// and the output register.
// ----------------------------------------------------------------------------
module ole_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ole_pkg::t_dp_cmd                  i_cmd,
    output ole_pkg::t_dp_status               o_status,
    input  logic [ole_pkg::ACT_W-1:0]         i_action,
    input  logic [ole_pkg::POS_W-1:0]         i_position,
    input  logic signed [ole_pkg::VAL_W-1:0]  i_item_value,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [1:0]                        o_out_status,
    output logic signed [ole_pkg::VAL_W-1:0]  o_out_value,
    output logic [ole_pkg::FPOS_W-1:0]        o_out_position,
    output logic [ole_pkg::LEN_W-1:0]         o_out_length
);
    import ole_pkg::*;

    logic signed [VAL_W-1:0] r_mem [CAPACITY];

    logic [ACT_W-1:0]        r_act;
    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_val;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        n_idx;
    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_rdata;

    t_status                 r_res_status;
    logic signed [VAL_W-1:0] r_res_value;
    logic [FPOS_W-1:0]       r_res_pos;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic signed [VAL_W-1:0] r_out_value;
    logic [FPOS_W-1:0]       r_out_pos;
    logic [LEN_W-1:0]        r_out_len;

    logic [CNT_W-1:0]        w_idx_m1;
    logic [CNT_W-1:0]        w_idx_p1;
    logic [IDX_W-1:0]        w_rd_addr;
    logic signed [VAL_W-1:0] w_wr_data;
    logic [31:0]             w_pos_ext;
    logic [31:0]             w_cnt_ext;
    logic [31:0]             w_idx_ext;

    assign w_idx_m1  = r_idx - CNT_W'(1);
    assign w_idx_p1  = r_idx + CNT_W'(1);
    assign w_pos_ext = 32'(r_pos);
    assign w_cnt_ext = 32'(r_count);
    assign w_idx_ext = 32'(r_idx);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: w_rd_addr = w_idx_m1[IDX_W-1:0];
            RD_IDX_P1: w_rd_addr = w_idx_p1[IDX_W-1:0];
            default:   w_rd_addr = r_idx[IDX_W-1:0];
        endcase
    end

    assign w_wr_data = (i_cmd.wr_sel == WR_PUT) ? r_val : r_rdata;

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx[IDX_W-1:0]] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count;
            IDX_POS:   n_idx = CNT_W'(r_pos);
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = w_idx_p1;
            IDX_DEC:   n_idx = w_idx_m1;
            default:   n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_req) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_src)
                RES_VAL: begin
                    r_res_value <= r_val;
                    r_res_pos   <= FPOS_W'(r_idx);
                end
                RES_ENTRY: begin
                    r_res_value <= r_rdata;
                    r_res_pos   <= FPOS_W'(r_idx);
                end
                default: begin
                    r_res_value <= '0;
                    r_res_pos   <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_pos    <= r_res_pos;
            r_out_len    <= LEN_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.act             = r_act;
    assign o_status.pos_gt_count    = w_pos_ext > w_cnt_ext;
    assign o_status.pos_ge_count    = w_pos_ext >= w_cnt_ext;
    assign o_status.count_full      = w_cnt_ext >= 32'(CAPACITY);
    assign o_status.idx_gt_pos      = w_idx_ext > w_pos_ext;
    assign o_status.idx_lt_count    = w_idx_ext < w_cnt_ext;
    assign o_status.idx_p1_lt_count = (w_idx_ext + 32'd1) < w_cnt_ext;
    assign o_status.val_match       = r_rdata == r_val;
    assign o_status.out_free        = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_value    = r_out_value;
    assign o_out_position = r_out_pos;
    assign o_out_length   = r_out_len;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_ext <= 32'(CAPACITY))
        else $error("list length exceeds capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (w_idx_ext < 32'(CAPACITY)) && (w_idx_ext <= w_cnt_ext))
        else $error("entry write outside the list");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && (r_res_status != ST_OK)) |->
            (r_res_value == '0) && (r_res_pos == '0))
        else $error("failed request carries nonzero value or position");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.cnt_inc && i_cmd.cnt_dec))
        else $error("length incremented and decremented together");
`endif

endmodule

>>> rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine: one request at a time. Positional requests go straight
// to their entry; search and remove-by-value scan from the front to the first
// match or the end. Insert shifts the entries from pos onward up by one; a
// remove shifts the later entries down. Each move is a read, then a write.
// Reset clears the length and the handshake state; the entry memory keeps junk.
// ----------------------------------------------------------------------------
module ordered_list_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ole_pkg::ACT_W-1:0]         i_action,
    input  logic [ole_pkg::POS_W-1:0]         i_position,
    input  logic signed [ole_pkg::VAL_W-1:0]  i_item_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [ole_pkg::VAL_W-1:0]  o_result_value,
    output logic [ole_pkg::FPOS_W-1:0]        o_found_position,
    output logic [ole_pkg::LEN_W-1:0]         o_list_length
);
    import ole_pkg::*;

    // A result waiting in the output register does not block the next
    // transfer: the engine takes a new request and only holds in its final
    // step until the output register frees up.

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_busy;
    logic       w_in_fire;

    // stall requests whenever the sequencer is working on one
    assign o_in_stall = w_busy;
    assign w_in_fire  = i_in_valid && !w_busy;

    ole_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_in_fire),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_busy    (w_busy)
    );

    // The datapath walks an index over the memory: upward to scan, downward
    // to open a gap on insert, upward again to close the gap on removal.
    ole_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_status   (o_status),
        .o_out_value    (o_result_value),
        .o_out_position (o_found_position),
        .o_out_length   (o_list_length)
    );

endmodule

>>> sim/tb_ordered_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Self-checking bench for the ordered list engine. A directed table covers
// empty-list errors, value extremes, reserved actions and duplicate handling.
// Random requests, mostly well-formed and aimed at live entries, follow. A
// final pass fills the list to capacity and works on the full list. Every
// result transfer is compared field by field with a typed table row or a queue-based list model.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
    import ole_pkg::*;

    // reserved action codes: the engine must reject these without side effects
    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_NEG1 = -32'sd1;

    localparam int DIR_ROWS          = 24;
    localparam int RAND_PER_PHASE    = 80;
    localparam int LONG_HOLD_CYCLES  = 400;
    // longest single request: remove at the front of a full list
    localparam int DRAIN_CYCLES      = 1100;
    localparam int MAX_REPORTS       = 10;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  value;
        logic [FPOS_W-1:0]        fpos;
        logic [LEN_W-1:0]         len;
    } t_list_result;

    typedef struct packed {
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  val;
        logic                     typed;
        t_list_result             res;
    } t_dir_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [ACT_W-1:0]          i_action;
    logic [POS_W-1:0]          i_position;
    logic signed [VAL_W-1:0]   i_item_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [1:0]                o_status;
    logic signed [VAL_W-1:0]   o_result_value;
    logic [FPOS_W-1:0]         o_found_position;
    logic [LEN_W-1:0]          o_list_length;

    // model of the list contents, front at index 0
    logic signed [VAL_W-1:0]   list_q [$];
    // results still owed by the engine, oldest first
    t_list_result              pending_results [$];

    int                        send_idle_pct;
    int                        recv_idle_pct;
    int                        hold_left;
    int                        error_count;
    int                        report_count;

    t_dir_row                  dir_rows [DIR_ROWS];

    ordered_list_engine i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_found_position (o_found_position),
        .o_list_length    (o_list_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("ordered_list_engine: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------

    // Return the index of the first entry equal to val, or -1.
    function automatic int first_index_of(input logic signed [VAL_W-1:0] val);
        foreach (list_q[k]) begin
            if (list_q[k] == val) return k;
        end
        return -1;
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic t_list_result predict_list_op(
        input logic [ACT_W-1:0]        act,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val
    );
        t_list_result r;
        int           idx;
        int           p;
        r      = '0;
        r.status = ST_OK;
        p      = int'(pos);
        case (act)
            ACT_INSERT: begin
                // range is checked before capacity
                if (p > list_q.size()) begin
                    r.status = ST_RANGE;
                end else if (list_q.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_q.insert(p, val);
                    r.value = val;
                    r.fpos  = pos[FPOS_W-1:0];
                end
            end
            ACT_REMOVE_POS, ACT_READ_POS: begin
                if (p >= list_q.size()) begin
                    r.status = ST_RANGE;
                end else begin
                    r.value = list_q[p];
                    r.fpos  = pos[FPOS_W-1:0];
                    if (act == ACT_REMOVE_POS) list_q.delete(p);
                end
            end
            ACT_REMOVE_VAL, ACT_SEARCH: begin
                idx = first_index_of(val);
                if (idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.value = list_q[idx];
                    r.fpos  = idx[FPOS_W-1:0];
                    if (act == ACT_REMOVE_VAL) list_q.delete(idx);
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.len = LEN_W'(list_q.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mix small values (to force duplicates), extremes and full-range values.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return $urandom_range(4) - 2;
        if (roll < 60) begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_NEG1;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    // Build one random request, biased toward targets that exist so most
    // requests reach the shift paths; keep the list short to bound latency.
    task automatic make_random_request(
        output logic [ACT_W-1:0]        act,
        output logic [POS_W-1:0]        pos,
        output logic signed [VAL_W-1:0] val
    );
        int roll;
        int len;
        int grow;
        len  = list_q.size();
        grow = (len < 24) ? 45 : ((len < 40) ? 30 : 8);
        roll = $urandom_range(99);
        val  = pick_value();
        if (roll < 3) begin
            case ($urandom_range(2))
                0:       act = ACT_RSVD5;
                1:       act = ACT_RSVD6;
                default: act = ACT_RSVD7;
            endcase
        end else if (roll < 3 + grow) begin
            act = ACT_INSERT;
        end else begin
            case ($urandom_range(3))
                0:       act = ACT_REMOVE_POS;
                1:       act = ACT_REMOVE_VAL;
                2:       act = ACT_READ_POS;
                default: act = ACT_SEARCH;
            endcase
        end
        // mostly legal positions, the rest anywhere in the field
        if ($urandom_range(9) == 0) begin
            pos = POS_W'($urandom_range((1 << POS_W) - 1));
        end else if (act == ACT_INSERT) begin
            pos = POS_W'($urandom_range(len));
        end else begin
            pos = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
        end
        if ((act inside {ACT_REMOVE_VAL, ACT_SEARCH}) && len > 0
                && $urandom_range(3) != 0) begin
            val = list_q[$urandom_range(len - 1)];
        end
    endtask

    // Offer one request, hold it through stalls, and record its expected
    // result once the transfer happens.
    task automatic offer_request(
        input logic [ACT_W-1:0]        act,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val,
        input logic                    typed,
        input t_list_result            typed_res
    );
        t_list_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_position   <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_list_op(act, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Hold off for a long counted stretch on request, else stall at random.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic flag_error(
        input string       what,
        input logic [31:0] exp_v,
        input logic [31:0] got_v
    );
        error_count = error_count + 1;
        if (report_count < MAX_REPORTS) begin
            report_count = report_count + 1;
            $display("check error at %0t: %s expected %h got %h",
                     $realtime, what, exp_v, got_v);
        end
    endtask

    // Compare each result transfer with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                flag_error("unexpected result, status", '0, 32'(o_status));
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                if (o_status !== exp_r.status)
                    flag_error("status", 32'(exp_r.status), 32'(o_status));
                if (o_result_value !== exp_r.value)
                    flag_error("result_value", exp_r.value, o_result_value);
                if (o_found_position !== exp_r.fpos)
                    flag_error("found_position", 32'(exp_r.fpos),
                               32'(o_found_position));
                if (o_list_length !== exp_r.len)
                    flag_error("list_length", 32'(exp_r.len), 32'(o_list_length));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [ACT_W-1:0]        act;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        int                      n;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = '0;
        i_position    = '0;
        i_item_value  = '0;
        hold_left     = 0;
        error_count   = 0;
        report_count  = 0;
        send_idle_pct = 30;
        recv_idle_pct = 80;

        // Directed table. Rows with typed results come straight from the
        // definition; the rest check against the model.
        dir_rows = '{
            // empty list: every lookup fails
            '{ACT_READ_POS,   9'd0,   32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd0}},
            '{ACT_SEARCH,     9'd0,   32'sd5,  1'b1, '{ST_NOTFOUND, 32'sd0, 8'd0, 9'd0}},
            '{ACT_REMOVE_VAL, 9'd0,   32'sd7,  1'b1, '{ST_NOTFOUND, 32'sd0, 8'd0, 9'd0}},
            '{ACT_REMOVE_POS, 9'd0,   32'sd0,  1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd0}},
            // insert past the end of an empty list
            '{ACT_INSERT,     9'd1,   32'sd9,  1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd0}},
            // build [-1, 0, MAX, MIN] using front, back and middle inserts
            '{ACT_INSERT,     9'd0,   VAL_MAX, 1'b1, '{ST_OK,       VAL_MAX, 8'd0, 9'd1}},
            '{ACT_INSERT,     9'd1,   VAL_MIN, 1'b1, '{ST_OK,       VAL_MIN, 8'd1, 9'd2}},
            '{ACT_INSERT,     9'd0,   VAL_NEG1, 1'b1, '{ST_OK,      VAL_NEG1, 8'd0, 9'd3}},
            '{ACT_INSERT,     9'd1,   32'sd0,  1'b1, '{ST_OK,       32'sd0, 8'd1, 9'd4}},
            // position extremes past the end
            '{ACT_INSERT,     9'd511, 32'sd3,  1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd4}},
            '{ACT_INSERT,     9'd256, 32'sd3,  1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd4}},
            // reserved actions leave the list alone
            '{ACT_RSVD5,      9'd511, VAL_MAX, 1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd4}},
            '{ACT_RSVD6,      9'd3,   VAL_NEG1, 1'b1, '{ST_RANGE,   32'sd0, 8'd0, 9'd4}},
            '{ACT_RSVD7,      9'd0,   VAL_MIN, 1'b1, '{ST_RANGE,    32'sd0, 8'd0, 9'd4}},
            // lookups, a duplicate, and removal of the first match only
            '{ACT_READ_POS,   9'd3,   32'sd0,  1'b0, '0},
            '{ACT_SEARCH,     9'd0,   VAL_MAX, 1'b0, '0},
            '{ACT_INSERT,     9'd2,   VAL_NEG1, 1'b0, '0},
            '{ACT_REMOVE_VAL, 9'd0,   VAL_NEG1, 1'b0, '0},
            '{ACT_SEARCH,     9'd0,   VAL_NEG1, 1'b0, '0},
            '{ACT_REMOVE_POS, 9'd3,   32'sd0,  1'b0, '0},
            '{ACT_REMOVE_POS, 9'd3,   32'sd0,  1'b0, '0},
            '{ACT_REMOVE_POS, 9'd0,   32'sd0,  1'b0, '0},
            '{ACT_READ_POS,   9'd1,   32'sd0,  1'b0, '0},
            '{ACT_SEARCH,     9'd0,   32'sd0,  1'b0, '0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++) begin
            offer_request(dir_rows[n].act, dir_rows[n].pos, dir_rows[n].val,
                          dir_rows[n].typed, dir_rows[n].res);
        end

        // phase 1: sender idles lightly, receiver heavily
        for (n = 0; n < RAND_PER_PHASE; n++) begin
            make_random_request(act, pos, val);
            offer_request(act, pos, val, 1'b0, '0);
        end

        // phase 2: swap the idle rates
        send_idle_pct = 80;
        recv_idle_pct = 30;
        for (n = 0; n < RAND_PER_PHASE; n++) begin
            make_random_request(act, pos, val);
            offer_request(act, pos, val, 1'b0, '0);
        end

        // phase 3: no idling; open with a long receiver hold-off so the
        // engine backs up and stalls the request side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = LONG_HOLD_CYCLES;
        for (n = 0; n < RAND_PER_PHASE; n++) begin
            make_random_request(act, pos, val);
            offer_request(act, pos, val, 1'b0, '0);
        end

        // fill to capacity, mostly appending to keep the pass short
        while (list_q.size() < CAPACITY) begin
            pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(list_q.size()))
                                           : POS_W'(list_q.size());
            offer_request(ACT_INSERT, pos, pick_value(), 1'b0, '0);
        end

        // full list: capacity and range errors, deep lookups, refill, shrink
        offer_request(ACT_INSERT,     9'd256, pick_value(), 1'b0, '0);
        offer_request(ACT_INSERT,     9'd0,   pick_value(), 1'b0, '0);
        offer_request(ACT_INSERT,     9'd257, pick_value(), 1'b0, '0);
        offer_request(ACT_READ_POS,   9'd255, '0,           1'b0, '0);
        offer_request(ACT_READ_POS,   9'd128, '0,           1'b0, '0);
        offer_request(ACT_READ_POS,   9'd256, '0,           1'b0, '0);
        offer_request(ACT_SEARCH,     9'd0,   list_q[200],  1'b0, '0);
        offer_request(ACT_SEARCH,     9'd0,   pick_value(), 1'b0, '0);
        offer_request(ACT_REMOVE_VAL, 9'd0,   list_q[250],  1'b0, '0);
        offer_request(ACT_INSERT,     9'd255, pick_value(), 1'b0, '0);
        offer_request(ACT_REMOVE_POS, 9'd255, '0,           1'b0, '0);
        offer_request(ACT_REMOVE_POS, 9'd0,   '0,           1'b0, '0);
        i_in_valid <= 1'b0;

        // drain owed results, then watch for stray transfers
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ordered_list_engine: match");
        end else begin
            $display("ordered_list_engine: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/ole_pkg.sv
rtl/ole_ctrl.sv
rtl/ole_dp.sv
rtl/ordered_list_engine.sv
sim/tb_ordered_list_engine.sv
